// ===== hdl/spd_pkg.sv =====
// Shared types and constants for the sync packet deframer.
// No dependencies; imported by every module of the block.
package spd_pkg;

   // Frame geometry: bytes numbered from 0, the sync pair being bytes 0 and 1
   localparam int FRAME_BYTES = 17;
   localparam int POS_W       = 5;

   localparam logic [POS_W-1:0] POS_ZERO    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_BODY    = POS_W'(2);
   localparam logic [POS_W-1:0] POS_SEQ     = POS_W'(3);
   localparam logic [POS_W-1:0] POS_ONE_HI  = POS_W'(4);
   localparam logic [POS_W-1:0] POS_ONE_LO  = POS_W'(5);
   localparam logic [POS_W-1:0] POS_TWO_HI  = POS_W'(6);
   localparam logic [POS_W-1:0] POS_TWO_LO  = POS_W'(7);
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);

   localparam logic [7:0] SYNC_FIRST  = 8'hA5;
   localparam logic [7:0] SYNC_SECOND = 8'h5A;
   localparam logic [7:0] SEQ_STEP    = 8'h01;

   // Token queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_GOT_FIRST,
      PH_BODY
   } phase_type;

   typedef enum logic [2:0] {
      FLD_NONE,
      FLD_SEQ,
      FLD_ONE_HI,
      FLD_ONE_LO,
      FLD_TWO_HI,
      FLD_TWO_LO
   } field_type;

   typedef struct packed {
      logic [7:0] data;
      field_type  field;
      logic       last;
   } token_type;

endpackage

// ===== hdl/spd_front.sv =====
// Front end: sync hunt and byte position tracking, emits field tokens.
// Depends on spd_pkg.
module spd_front import spd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       q_full,
   output logic       push,
   output token_type  push_token
);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;

   // next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      if (accept) begin
         case (phase_ff)
            PH_GOT_FIRST: begin
               // broken pair: this byte is consumed, never retested
               if (req_rx_byte == SYNC_SECOND) begin
                  phase_in = PH_BODY;
                  pos_in   = POS_BODY;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_BODY: begin
               if (pos_ff == POS_LAST) begin
                  phase_in = PH_HUNT;
                  pos_in   = POS_ZERO;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
            default: begin
               phase_in = (req_rx_byte == SYNC_FIRST) ? PH_GOT_FIRST : PH_HUNT;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      push_token.data  = req_rx_byte;
      push_token.field = FLD_NONE;
      push_token.last  = 1'b0;
      if (phase_ff == PH_BODY) begin
         push_token.last = (pos_ff == POS_LAST);
         unique case (pos_ff)
            POS_SEQ:    push_token.field = FLD_SEQ;
            POS_ONE_HI: push_token.field = FLD_ONE_HI;
            POS_ONE_LO: push_token.field = FLD_ONE_LO;
            POS_TWO_HI: push_token.field = FLD_TWO_HI;
            POS_TWO_LO: push_token.field = FLD_TWO_LO;
            default:    push_token.field = FLD_NONE;
         endcase
      end
      push = accept && (phase_ff == PH_BODY) &&
             ((push_token.field != FLD_NONE) || push_token.last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= POS_ZERO;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// ===== hdl/spd_fifo.sv =====
// Short token queue between the front and back ends.
// Depends on spd_pkg.
module spd_fifo import spd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   output logic      full,
   input  logic      pop,
   output token_type pop_token,
   output logic      empty
);

   token_type             store_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_token = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("token queue count beyond depth");

   a_push_dropped: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("token pushed into full queue");

endmodule

// ===== hdl/spd_back.sv =====
// Back end: assembles frame fields from tokens, checks sequence, holds result.
// Depends on spd_pkg.
module spd_back import spd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  token_type   pop_token,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_channel_one,
   output logic [15:0] rsp_channel_two,
   output logic [7:0]  rsp_sequence_res,
   output logic        rsp_dropped
);

   logic [7:0]  seq_ff, seq_in;
   logic [15:0] one_ff, one_in;
   logic [15:0] two_ff, two_in;
   logic [7:0]  last_seq_ff, last_seq_in;
   logic        seen_ff, seen_in;
   logic        valid_ff, valid_in;
   logic [15:0] out_one_ff, out_one_in;
   logic [15:0] out_two_ff, out_two_in;
   logic [7:0]  out_seq_ff, out_seq_in;
   logic        out_drop_ff, out_drop_in;
   logic        finish, drop;

   // a frame end may only leave the queue when the result register frees up
   assign pop    = !q_empty && (!pop_token.last || !valid_ff || rsp_ready);
   assign finish = pop && pop_token.last;

   always_comb begin
      seq_in = seq_ff;
      one_in = one_ff;
      two_in = two_ff;
      if (pop) begin
         unique case (pop_token.field)
            FLD_SEQ:    seq_in = pop_token.data;
            FLD_ONE_HI: one_in = {pop_token.data, one_ff[7:0]};
            FLD_ONE_LO: one_in = {one_ff[15:8], pop_token.data};
            FLD_TWO_HI: two_in = {pop_token.data, two_ff[7:0]};
            FLD_TWO_LO: two_in = {two_ff[15:8], pop_token.data};
            default:    ;
         endcase
      end
      drop = seen_ff && ((seq_in - last_seq_ff) != SEQ_STEP);

      last_seq_in = finish ? seq_in : last_seq_ff;
      seen_in     = seen_ff || finish;
      out_one_in  = finish ? one_in : out_one_ff;
      out_two_in  = finish ? two_in : out_two_ff;
      out_seq_in  = finish ? seq_in : out_seq_ff;
      out_drop_in = finish ? drop   : out_drop_ff;
      priority if (finish) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff     <= seq_in;
      one_ff     <= one_in;
      two_ff     <= two_in;
      out_one_ff <= out_one_in;
      out_two_ff <= out_two_in;
      out_seq_ff <= out_seq_in;
      out_drop_ff <= out_drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff <= '0;
         seen_ff     <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         last_seq_ff <= last_seq_in;
         seen_ff     <= seen_in;
         valid_ff    <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_channel_one  = out_one_ff;
   assign rsp_channel_two  = out_two_ff;
   assign rsp_sequence_res = out_seq_ff;
   assign rsp_dropped      = out_drop_ff;

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      finish |=> valid_ff)
      else $error("frame end did not load result register");

   a_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_ff |=> seen_ff)
      else $error("frame seen flag cleared");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_drop_ff) |-> seen_ff)
      else $error("drop flagged before any frame seen");

endmodule

// ===== hdl/sync_packet_deframer_core.sv =====
// Top level of the sync packet deframer: front end, token queue, back end.
// Depends on spd_pkg, spd_front, spd_fifo and spd_back.
//
// Usage:
//  - req_ channel carries one received serial byte per transaction
//    (req_rx_byte). Bytes are hunted for the sync pair A5 5A; a byte after
//    A5 that is not 5A is swallowed. After the pair the rest of a
//    FRAME_BYTES frame is collected; sync values inside a frame are data.
//  - rsp_ channel carries one transaction per complete frame: the two
//    big-endian samples (bytes 4,5 and 6,7), the sequence byte (byte 3)
//    and a dropped flag, set when an earlier frame exists and the sequence
//    did not advance by one modulo 256.
//  - Throughput: one byte per cycle while the token queue is not full. The last frame
//    byte reaches rsp_valid through the queue write, then the result register.
//  - The front end only queues the bytes that carry fields plus the frame
//    end, so a stalled receiver backs up the 4-entry token queue before
//    req_ready drops; bytes keep flowing into the queue while a result waits.
//  - Reset (synchronous, active high) returns to hunting, empties the queue,
//    clears the pending result and forgets any earlier frame.
module sync_packet_deframer_core import spd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_channel_one,
   output logic [15:0] rsp_channel_two,
   output logic [7:0]  rsp_sequence_res,
   output logic        rsp_dropped
);

   token_type push_token, pop_token;
   logic      push, pop, q_full, q_empty;

   // hunt and position tracking
   spd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .push        (push),
      .push_token  (push_token)
   );

   // decouples the byte stream from result backpressure
   spd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (q_full),
      .pop        (pop),
      .pop_token  (pop_token),
      .empty      (q_empty)
   );

   // field assembly, sequence check and result register
   spd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .pop_token        (pop_token),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel_one  (rsp_channel_one),
      .rsp_channel_two  (rsp_channel_two),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_dropped      (rsp_dropped)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for sync_packet_deframer_core: serial bytes in, frame results out.
// Depends on spd_pkg and the deframer RTL. The expected frames come from a behavioural
// deframer kept in step with every accepted byte.
module tb;
   import spd_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 6;
   localparam int IDLE_PERCENT    = 13;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STALL_LIMIT     = 2000;

   // One frame result as seen on the rsp_ channel
   typedef struct packed {
      logic [15:0] one;
      logic [15:0] two;
      logic [7:0]  seq;
      logic        dropped;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_channel_one;
   logic [15:0] rsp_channel_two;
   logic [7:0]  rsp_sequence_res;
   logic        rsp_dropped;

   // Behavioural deframer state; hunt, position and sequence history mirror the block's reset values
   phase_type        hunt_phase    = PH_HUNT;
   logic [POS_W-1:0] frame_pos     = POS_ZERO;
   logic [7:0]       held_seq      = 8'h00;
   logic [15:0]      held_one      = 16'h0000;
   logic [15:0]      held_two      = 16'h0000;
   logic [7:0]       last_seq      = 8'h00;
   logic             frame_seen    = 1'b0;

   frame_result_type pending_frames[$];   // frames predicted but not yet received
   int unsigned   bytes_accepted = 0;
   int unsigned   mismatches     = 0;
   int unsigned   quiet_cycles   = 0;
   logic [7:0]    stim_seq       = 8'h00;  // sequence number the stimulus will use next
   bit            idling_on      = 1'b1;   // random gaps on both channels
   bit            hold_off_request = 1'b0; // asks the receiver for one long stall

   sync_packet_deframer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel_one  (rsp_channel_one),
      .rsp_channel_two  (rsp_channel_two),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_dropped      (rsp_dropped)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Advance the behavioural deframer by one byte; queue a frame result at frame end.
   function automatic void deframe_byte(input logic [7:0] rx);
      frame_result_type done;
      case (hunt_phase)
         PH_GOT_FIRST: begin
            // second byte of the pair; anything but 5A is swallowed
            if (rx == SYNC_SECOND) begin
               hunt_phase = PH_BODY;
               frame_pos  = POS_BODY;
            end else begin
               hunt_phase = PH_HUNT;
            end
         end
         PH_BODY: begin
            case (frame_pos)
               POS_SEQ:    held_seq        = rx;
               POS_ONE_HI: held_one[15:8]  = rx;
               POS_ONE_LO: held_one[7:0]   = rx;
               POS_TWO_HI: held_two[15:8]  = rx;
               POS_TWO_LO: held_two[7:0]   = rx;
               default: ;
            endcase
            if (frame_pos != POS_LAST) begin
               frame_pos = frame_pos + POS_W'(1);
            end else begin
               done.one     = held_one;
               done.two     = held_two;
               done.seq     = held_seq;
               // no earlier frame means nothing can have been dropped
               done.dropped = frame_seen && (8'(held_seq - last_seq) != SEQ_STEP);
               pending_frames.push_back(done);
               last_seq   = held_seq;
               frame_seen = 1'b1;
               hunt_phase = PH_HUNT;
               frame_pos  = POS_ZERO;
            end
         end
         default: begin
            hunt_phase = (rx == SYNC_FIRST) ? PH_GOT_FIRST : PH_HUNT;
         end
      endcase
   endfunction

   // Random byte, biased towards the sync values and the extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0:       return SYNC_FIRST;
         1:       return SYNC_SECOND;
         2:       return 8'h00;
         3:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Offer one byte and hold it until the transaction completes
   task automatic send_byte(input logic [7:0] value);
      while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      deframe_byte(value);
      bytes_accepted++;
   endtask

   // Whole frame: sync pair, ignored byte 2, fields, then filler up to frame end.
   // With sync_filler set the ignored bytes are sync values, which must be taken as data.
   task automatic send_frame(input logic [7:0] seq, input logic [15:0] one,
                             input logic [15:0] two, input bit sync_filler);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(sync_filler ? SYNC_FIRST : pick_byte());
      send_byte(seq);
      send_byte(one[15:8]);
      send_byte(one[7:0]);
      send_byte(two[15:8]);
      send_byte(two[7:0]);
      for (int i = 8; i < FRAME_BYTES; i++) begin
         if (sync_filler)
            send_byte(i[0] ? SYNC_SECOND : SYNC_FIRST);
         else
            send_byte(pick_byte());
      end
   endtask

   // Broken pairs, a stray second sync byte, then a first frame with extreme fields
   task automatic test_sync_hunting();
      send_byte(8'h00);
      send_byte(SYNC_FIRST);
      send_byte(8'h33);          // broken pair, hunt restarts
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);     // swallowed, not taken as a new first byte
      send_byte(SYNC_SECOND);    // so this one is plain noise
      send_byte(SYNC_SECOND);
      // first frame: sequence far from zero yet not flagged
      send_frame(8'hFF, 16'hFFFF, 16'h0000, 1'b1);
      stim_seq = 8'h00;
   endtask

   // Mostly well-formed frames with random content, mixed with noise and broken pairs
   task automatic random_stream(input int unsigned count);
      int unsigned stop_at;
      stop_at = bytes_accepted + count;
      while (bytes_accepted < stop_at) begin
         case ($urandom_range(19))
            0, 1, 2: begin
               send_byte(SYNC_FIRST);
               send_byte(pick_byte());
            end
            3, 4: begin
               repeat ($urandom_range(1, 6)) send_byte(pick_byte());
            end
            default: begin
               repeat ($urandom_range(2)) send_byte(8'($urandom));
               // in order most of the time; repeats, jumps and a wrap from FF now and then
               case ($urandom_range(9))
                  7:       stim_seq = stim_seq - 8'h01;
                  8:       stim_seq = 8'hFF;
                  9:       stim_seq = 8'($urandom);
                  default: ;
               endcase
               send_frame(stim_seq, 16'($urandom), 16'($urandom), 1'b0);
               stim_seq = stim_seq + 8'h01;
            end
         endcase
      end
   endtask

   task automatic test_random_traffic();
      random_stream(700);
      // back-to-back stretch, no gaps on either side
      idling_on = 1'b0;
      random_stream(400);
      idling_on = 1'b1;
      random_stream(500);
   endtask

   // Receiver stalls for a long time while frames keep coming, so req_ready must drop
   task automatic test_receiver_backpressure();
      idling_on        = 1'b0;
      hold_off_request = 1'b1;
      repeat (12) begin
         send_frame(stim_seq, 16'($urandom), 16'($urandom), 1'b0);
         stim_seq = stim_seq + 8'h01;
      end
      idling_on = 1'b1;
   endtask

   task automatic check_field(input string field_name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
         mismatches++;
      end
   endtask

   // Every completed rsp_ transaction is matched against the oldest predicted frame
   always @(posedge clock) begin : result_checker
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected frame, expected none, actual seq %h one %h two %h drop %b",
                     $time, rsp_sequence_res, rsp_channel_one, rsp_channel_two, rsp_dropped);
            mismatches++;
         end else begin
            want = pending_frames.pop_front();
            check_field("channel_one", want.one, rsp_channel_one);
            check_field("channel_two", want.two, rsp_channel_two);
            check_field("sequence_res", 16'(want.seq), 16'(rsp_sequence_res));
            check_field("dropped", 16'(want.dropped), 16'(rsp_dropped));
         end
      end
   end

   // Receiver: random gaps, plus one long hold-off when asked
   initial begin : receiver
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end
         rsp_ready <= !(idling_on && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sync_hunting();
      test_receiver_backpressure();
      test_random_traffic();

      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      // catch any late, unrequested frame
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sync_packet_deframer_core.f =====
hdl/spd_pkg.sv
hdl/spd_front.sv
hdl/spd_fifo.sv
hdl/spd_back.sv
hdl/sync_packet_deframer_core.sv
tb/tb.sv
